/* rtl/core/fih_pkg.sv */
`default_nettype none

package fih_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int KEY_W       = 64;
  localparam int ENTRY_W     = 2 * KEY_W + 1;

  localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  PROBE_MAX = CNT_W'(TABLE_SLOTS);
  // Insert refused once (count + 1) * 2 reaches the slot count
  localparam logic [CNT_W:0]    LOAD_LIM  = (CNT_W + 1)'((TABLE_SLOTS + 1) / 2);

  // Operation code
  localparam logic OP_INSERT = 1'b1;

  // Hash constants
  localparam logic [KEY_W-1:0] GOLDEN_MUL = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [KEY_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [KEY_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

  typedef enum logic {
    HS_IDLE,
    HS_RUN
  } hash_state_t;

  typedef enum logic [1:0] {
    PS_CLEAR,
    PS_IDLE,
    PS_CHECK,
    PS_DONE
  } probe_state_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] slot;
  } hash_res_t;

  typedef struct packed {
    logic clearing;
    logic res_valid;
    logic found;
    logic inserted;
    logic full;
  } probe_stat_t;

endpackage

`default_nettype wire

/* rtl/core/fih_in_if.sv */
`default_nettype none

interface fih_in_if import fih_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] device_id;
  logic [KEY_W-1:0] inode_id;

  modport source (output valid, output operation, output device_id, output inode_id,
                  input ready);
  modport sink (input valid, input operation, input device_id, input inode_id,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/fih_out_if.sv */
`default_nettype none

interface fih_out_if;
  logic valid;
  logic ready;
  logic found;
  logic inserted;
  logic full_res;

  modport source (output valid, output found, output inserted, output full_res,
                  input ready);
  modport sink (input valid, input found, input inserted, input full_res,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/fih_ram.sv */
`default_nettype none

module fih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/fih_hash.sv */
`default_nettype none

module fih_hash import fih_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] dev,
  input  wire logic [KEY_W-1:0] ino,
  output hash_res_t             hres
);

  localparam logic [1:0] MUL_GOLD = 2'd0;
  localparam logic [1:0] MUL_A    = 2'd1;
  localparam logic [1:0] STP_LOLO = 2'd0;
  localparam logic [1:0] STP_HILO = 2'd1;
  localparam logic [1:0] STP_LOHI = 2'd2;
  localparam logic [1:0] STP_SUM  = 2'd3;

  hash_state_t       hs_r, hs_nxt;
  logic [1:0]        mul_r, mul_nxt;
  logic [1:0]        stp_r, stp_nxt;
  logic [KEY_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0]  ino_r, ino_nxt;
  logic [KEY_W-1:0]  prod_r, prod_nxt;
  logic [KEY_W-1:0]  acc_r, acc_nxt;
  logic              done_r, done_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [KEY_W-1:0]  kmul;
  logic [31:0]       a_half;
  logic [31:0]       k_half;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  m;
  logic [KEY_W-1:0]  mx0;
  logic [KEY_W-1:0]  hash;

  // Select the multiplier constant for this round
  always_comb begin
    case (mul_r)
      MUL_GOLD: kmul = GOLDEN_MUL;
      MUL_A:    kmul = MIX_MUL_A;
      default:  kmul = MIX_MUL_B;
    endcase
  end

  // One 32x32 partial product per cycle; only the low 64 bits of each round matter
  assign a_half = (stp_r == STP_HILO) ? op_r[63:32] : op_r[31:0];
  assign k_half = (stp_r == STP_LOHI) ? kmul[63:32] : kmul[31:0];
  assign prod   = {32'b0, a_half} * {32'b0, k_half};

  assign m    = acc_r + prod_r;
  assign mx0  = ino_r ^ m;
  assign hash = m ^ (m >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= HS_IDLE;
      mul_r  <= 2'd0;
      stp_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      hs_r   <= hs_nxt;
      mul_r  <= mul_nxt;
      stp_r  <= stp_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ino_r  <= ino_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    slot_r <= slot_nxt;
  end

  // Sequence three rounds of four steps each
  always_comb begin
    hs_nxt   = hs_r;
    mul_nxt  = mul_r;
    stp_nxt  = stp_r;
    op_nxt   = op_r;
    ino_nxt  = ino_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    slot_nxt = slot_r;
    case (hs_r)
      HS_IDLE: begin
        if (start) begin
          hs_nxt  = HS_RUN;
          mul_nxt = MUL_GOLD;
          stp_nxt = STP_LOLO;
          op_nxt  = dev;
          ino_nxt = ino;
        end
      end
      HS_RUN: begin
        stp_nxt = stp_r + 2'd1;
        case (stp_r)
          STP_LOLO: begin
            prod_nxt = prod;
          end
          STP_HILO: begin
            acc_nxt  = prod_r;
            prod_nxt = {prod[31:0], 32'b0};
          end
          STP_LOHI: begin
            acc_nxt  = acc_r + prod_r;
            prod_nxt = {prod[31:0], 32'b0};
          end
          STP_SUM: begin
            // Round finished: apply the xor-shift and feed the next round, or after the last round register the slot
            mul_nxt = mul_r + 2'd1;
            case (mul_r)
              MUL_GOLD: op_nxt = mx0 ^ (mx0 >> 30);
              MUL_A:    op_nxt = m ^ (m >> 27);
              default: begin
                hs_nxt   = HS_IDLE;
                done_nxt = 1'b1;
                slot_nxt = hash[SLOT_W-1:0] & SLOT_MASK;
              end
            endcase
          end
          default: stp_nxt = STP_LOLO;
        endcase
      end
      default: hs_nxt = HS_IDLE;
    endcase
  end

  assign hres.done = done_r;
  assign hres.slot = slot_r;

endmodule

`default_nettype wire

/* rtl/core/fih_probe.sv */
`default_nettype none

module fih_probe import fih_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hash_res_t        hres,
  input  wire logic             insert,
  input  wire logic [KEY_W-1:0] dev,
  input  wire logic [KEY_W-1:0] ino,
  input  wire logic             ack,
  output probe_stat_t           stat
);

  probe_state_t      state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              found_r, found_nxt;
  logic              ins_r, ins_nxt;
  logic              full_r, full_nxt;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [SLOT_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;

  logic              rd_valid;
  logic              hit;
  logic              room;
  logic [SLOT_W-1:0] next_slot;

  // Slot store: {valid, device, inode}
  fih_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_valid  = rdata[ENTRY_W-1];
  assign hit       = rd_valid && (rdata[2*KEY_W-1:KEY_W] == dev)
                     && (rdata[KEY_W-1:0] == ino);
  assign room      = ({1'b0, count_r} + 1'b1) < LOAD_LIM;
  assign next_slot = (slot_r + 1'b1) & SLOT_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_CLEAR;
      slot_r  <= '0;
      steps_r <= '0;
      count_r <= '0;
      found_r <= 1'b0;
      ins_r   <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      steps_r <= steps_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      ins_r   <= ins_nxt;
      full_r  <= full_nxt;
    end
  end

  // Clear after reset, then one slot read per cycle until free, hit or wrap
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    found_nxt = found_r;
    ins_nxt   = ins_r;
    full_nxt  = full_r;
    we        = 1'b0;
    waddr     = slot_r;
    wdata     = {1'b1, dev, ino};
    raddr     = slot_r;
    case (state_r)
      PS_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        slot_nxt = slot_r + 1'b1;
        // The mask equals the last slot index
        if (slot_r == SLOT_MASK) begin
          slot_nxt  = '0;
          state_nxt = PS_IDLE;
        end
      end
      PS_IDLE: begin
        if (hres.done) begin
          raddr     = hres.slot;
          slot_nxt  = hres.slot;
          steps_nxt = '0;
          found_nxt = 1'b0;
          ins_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = PS_CHECK;
        end
      end
      PS_CHECK: begin
        if (!rd_valid) begin
          // Free slot: key absent, store it if allowed
          state_nxt = PS_DONE;
          if (insert == OP_INSERT) begin
            if (room) begin
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
              ins_nxt   = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end
        end else if (hit) begin
          found_nxt = 1'b1;
          state_nxt = PS_DONE;
        end else if ((steps_r + 1'b1) == PROBE_MAX) begin
          // Whole table visited without a free slot
          full_nxt  = (insert == OP_INSERT);
          state_nxt = PS_DONE;
        end else begin
          raddr     = next_slot;
          slot_nxt  = next_slot;
          steps_nxt = steps_r + 1'b1;
        end
      end
      PS_DONE: begin
        if (ack) begin
          state_nxt = PS_IDLE;
        end
      end
      default: state_nxt = PS_IDLE;
    endcase
  end

  assign stat.clearing  = (state_r == PS_CLEAR);
  assign stat.res_valid = (state_r == PS_DONE);
  assign stat.found     = found_r;
  assign stat.inserted  = ins_r;
  assign stat.full      = full_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == PS_DONE |-> $onehot0({found_r, ins_r, full_r}))
    else $error("more than one result flag set");

  a_load_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} < LOAD_LIM))
    else $error("entry count past load limit");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PS_CHECK && we) |=> (count_r == $past(count_r) + 1'b1) && ins_r)
    else $error("insert without count update");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == PS_CLEAR || state_r == PS_CHECK))
    else $error("slot write outside clear or probe");

endmodule

`default_nettype wire

/* rtl/core/file_identity_hash_set.sv */
// Flow: the accepted key is hashed, then the probe visits 1..1024 slots, and the result is moved
// into the output register; no new item is taken until that result has left the probe. The hash
// runs on one shared 32x32 multiplier, then the probe reads one slot per cycle from the slot memory.
// Reset: rst_n synchronous, active low; afterwards a clearing pass writes all
// 1024 slots, one per cycle, and in_chan.ready stays low during that pass.
`default_nettype none

module file_identity_hash_set import fih_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  fih_in_if.sink    in_chan,
  fih_out_if.source out_chan
);

  logic             busy_r, busy_nxt;
  logic             op_r;
  logic [KEY_W-1:0] dev_r;
  logic [KEY_W-1:0] ino_r;
  logic             out_valid_r, out_valid_nxt;
  logic             found_r;
  logic             ins_r;
  logic             full_r;

  logic             accept;
  logic             take;
  hash_res_t        hres;
  probe_stat_t      stat;

  assign in_chan.ready = !busy_r && !stat.clearing;
  assign accept        = in_chan.valid && in_chan.ready;
  // Move a finished result into the output register when it is free
  assign take          = stat.res_valid && (!out_valid_r || out_chan.ready);

  fih_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .dev   (in_chan.device_id),
    .ino   (in_chan.inode_id),
    .hres  (hres)
  );

  fih_probe u_probe (
    .clk    (clk),
    .rst_n  (rst_n),
    .hres   (hres),
    .insert (op_r),
    .dev    (dev_r),
    .ino    (ino_r),
    .ack    (take),
    .stat   (stat)
  );

  // Hold the accepted key for the probe and capture the result flags when a result is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.operation;
      dev_r <= in_chan.device_id;
      ino_r <= in_chan.inode_id;
    end
    if (take) begin
      found_r <= stat.found;
      ins_r   <= stat.inserted;
      full_r  <= stat.full;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (take) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.found    = found_r;
  assign out_chan.inserted = ins_r;
  assign out_chan.full_res = full_r;

endmodule

`default_nettype wire
